/* design/pdq_pkg.sv */
// package for the palette downscale quantizer
// holds the fsm state type, the command and register codes and the target palette table
// no dependencies
package pdq_pkg;

    localparam int CFG_W          = 16;
    localparam int DEF_MAX_OUT_W  = 128;
    localparam int DEF_MAX_OUT_H  = 128;
    localparam int PAL_DEPTH      = 256;
    localparam int DIST_W         = 18;

    localparam logic [DIST_W-1:0] DIST_INIT = '1;
    localparam logic [7:0] QUIRK_MIN = 8'd248;
    localparam logic [7:0] QUIRK_IDX = 8'd255;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEARCH,
        ST_EMIT,
        ST_DIVC,
        ST_ADV,
        ST_DIVR
    } t_state;

    // target palette, red in the top byte
    localparam logic [23:0] TGT_PAL [PAL_DEPTH] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA, 24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF, 24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF,
        24'h000000, 24'h141414, 24'h202020, 24'h2C2C2C, 24'h383838, 24'h454545, 24'h515151, 24'h616161,
        24'h717171, 24'h828282, 24'h929292, 24'hA2A2A2, 24'hB6B6B6, 24'hCBCBCB, 24'hE3E3E3, 24'hFFFFFF,
        24'h0000FF, 24'h4100FF, 24'h7D00FF, 24'hBE00FF, 24'hFF00FF, 24'hFF00BE, 24'hFF007D, 24'hFF0041,
        24'hFF0000, 24'hFF4100, 24'hFF7D00, 24'hFFBE00, 24'hFFFF00, 24'hBEFF00, 24'h7DFF00, 24'h41FF00,
        24'h00FF00, 24'h00FF41, 24'h00FF7D, 24'h00FFBE, 24'h00FFFF, 24'h00BEFF, 24'h007DFF, 24'h0041FF,
        24'h7D7DFF, 24'h9E7DFF, 24'hBE7DFF, 24'hDF7DFF, 24'hFF7DFF, 24'hFF7DDF, 24'hFF7DBE, 24'hFF7D9E,
        24'hFF7D7D, 24'hFF9E7D, 24'hFFBE7D, 24'hFFDF7D, 24'hFFFF7D, 24'hDFFF7D, 24'hBEFF7D, 24'h9EFF7D,
        24'h7DFF7D, 24'h7DFF9E, 24'h7DFFBE, 24'h7DFFDF, 24'h7DFFFF, 24'h7DDFFF, 24'h7DBEFF, 24'h7D9EFF,
        24'hB6B6FF, 24'hC7B6FF, 24'hDBB6FF, 24'hEBB6FF, 24'hFFB6FF, 24'hFFB6EB, 24'hFFB6DB, 24'hFFB6C7,
        24'hFFB6B6, 24'hFFC7B6, 24'hFFDBB6, 24'hFFEBB6, 24'hFFFFB6, 24'hEBFFB6, 24'hDBFFB6, 24'hC7FFB6,
        24'hB6FFB6, 24'hB6FFC7, 24'hB6FFDB, 24'hB6FFEB, 24'hB6FFFF, 24'hB6EBFF, 24'hB6DBFF, 24'hB6C7FF,
        24'h000071, 24'h1C0071, 24'h380071, 24'h550071, 24'h710071, 24'h710055, 24'h710038, 24'h71001C,
        24'h710000, 24'h711C00, 24'h713800, 24'h715500, 24'h717100, 24'h557100, 24'h387100, 24'h1C7100,
        24'h007100, 24'h00711C, 24'h007138, 24'h007155, 24'h007171, 24'h005571, 24'h003871, 24'h001C71,
        24'h383871, 24'h453871, 24'h553871, 24'h613871, 24'h713871, 24'h713861, 24'h713855, 24'h713845,
        24'h713838, 24'h714538, 24'h715538, 24'h716138, 24'h717138, 24'h617138, 24'h557138, 24'h457138,
        24'h387138, 24'h387145, 24'h387155, 24'h387161, 24'h387171, 24'h386171, 24'h385571, 24'h384571,
        24'h515171, 24'h595171, 24'h615171, 24'h695171, 24'h715171, 24'h715169, 24'h715161, 24'h715159,
        24'h715151, 24'h715951, 24'h716151, 24'h716951, 24'h717151, 24'h697151, 24'h617151, 24'h597151,
        24'h517151, 24'h517159, 24'h517161, 24'h517169, 24'h517171, 24'h516971, 24'h516171, 24'h515971,
        24'h000041, 24'h100041, 24'h200041, 24'h300041, 24'h410041, 24'h410030, 24'h410020, 24'h410010,
        24'h410000, 24'h411000, 24'h412000, 24'h413000, 24'h414100, 24'h304100, 24'h204100, 24'h104100,
        24'h004100, 24'h004110, 24'h004120, 24'h004130, 24'h004141, 24'h003041, 24'h002041, 24'h001041,
        24'h202041, 24'h282041, 24'h302041, 24'h382041, 24'h412041, 24'h412038, 24'h412030, 24'h412028,
        24'h412020, 24'h412820, 24'h413020, 24'h413820, 24'h414120, 24'h384120, 24'h304120, 24'h284120,
        24'h204120, 24'h204128, 24'h204130, 24'h204138, 24'h204141, 24'h203841, 24'h203041, 24'h202841,
        24'h2C2C41, 24'h302C41, 24'h342C41, 24'h3C2C41, 24'h412C41, 24'h412C3C, 24'h412C34, 24'h412C30,
        24'h412C2C, 24'h41302C, 24'h41342C, 24'h413C2C, 24'h41412C, 24'h3C412C, 24'h34412C, 24'h30412C,
        24'h2C412C, 24'h2C4130, 24'h2C4134, 24'h2C413C, 24'h2C4141, 24'h2C3C41, 24'h2C3441, 24'h2C3041,
        24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000
    };

endpackage

/* design/palette_downscale_quantizer.sv */
// top level of the palette downscale quantizer
// depends on pdq_pkg (types, codes, target palette) and pdq_div (position divider)
//
// usage:
//   the input stream carries two kinds of request, chosen by s_axis_tuser: a palette
//   load (writes one rgb entry of the source palette) or a pixel (one indexed source
//   pixel in bottom-up file order). the output stream carries one request per kept
//   pixel: nearest target palette index, output column and top-down output row, with
//   tlast on the final pixel of the tile.
//   the configuration port sets source width and height; a write restarts the frame
//   position but keeps the source palette. write it only while the block is idle.
//   handling, one request at a time:
//     palette load: written straight from the idle state
//     skipped pixel: eval and advance states, plus a divider run at the end of a kept source row
//     kept pixel: a search over the 256 target entries (one
//       rom entry per cycle through a two stage distance pipe), then a divider run
//       for the next sample column; the divider width DW is 24 by default
//   reset clears the position counters and marks every source palette entry as black
//   through one valid flop per entry; no clearing pass is needed.
//   a finished result sits in the output register; the next request is taken while
//   it waits, and the block only stalls when a second result is ready before the
//   first one has been taken.
module palette_downscale_quantizer #(
    parameter int MAX_OUT_WIDTH  = pdq_pkg::DEF_MAX_OUT_W,
    parameter int MAX_OUT_HEIGHT = pdq_pkg::DEF_MAX_OUT_H
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24], pixel_value[39:32]
    input  logic [39:0] s_axis_tdata,
    // cmd[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tile_index[7:0], out_column[14:8], out_row[21:15], zero fill[23:22]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import pdq_pkg::*;

    localparam int CW = $clog2(MAX_OUT_WIDTH + 1);
    localparam int CH = $clog2(MAX_OUT_HEIGHT + 1);
    localparam int CD = (CW > CH) ? CW : CH;
    localparam int DW = CD + CFG_W;

    // configuration
    logic [CFG_W-1:0] r_src_w, r_src_h;
    logic [CW-1:0]    w_clamp;
    logic [CH-1:0]    h_clamp;

    // frame position
    logic [CFG_W-1:0] r_src_col, r_src_row, r_want_col, r_want_row;
    logic [CW-1:0]    r_out_col;
    logic [CH-1:0]    r_out_row;
    logic             r_done;

    t_state r_state, n_state;

    // source palette: memory plus one valid flop per entry for the black reset
    logic [23:0] r_pal_mem [PAL_DEPTH];
    logic        r_pal_vld [PAL_DEPTH];
    logic [23:0] r_pal_rdata;
    logic        r_pal_hit;
    logic [23:0] pix_rgb;

    // search pipe
    logic [8:0]        r_cnt;
    logic              r_s1_vld;
    logic [7:0]        r_s1_idx;
    logic [15:0]       r_sq_r, r_sq_g, r_sq_b;
    logic [DIST_W-1:0] r_best_dist;
    logic [7:0]        r_best_idx;
    logic [23:0]       rom_rgb;
    logic signed [8:0] d_r, d_g, d_b;
    logic [DIST_W-1:0] sq_dist;

    // output register
    logic        r_m_vld;
    logic [23:0] r_m_data;
    logic        r_m_last;

    // divider
    logic          div_start, div_busy, div_done;
    logic [DW-1:0] div_dividend, div_q;
    logic [CD-1:0] div_divisor;

    logic          in_fire, emit_fire, keep, ignore, fin, wrap, row_hit;
    logic [CW-1:0] n_out_col;
    logic [CH-1:0] n_out_row;
    logic [16:0]   n_src_col;
    logic [7:0]    tile_idx;
    logic [6:0]    row7;

    assign w_clamp = (r_src_w > CFG_W'(MAX_OUT_WIDTH))  ? CW'(MAX_OUT_WIDTH)  : CW'(r_src_w);
    assign h_clamp = (r_src_h > CFG_W'(MAX_OUT_HEIGHT)) ? CH'(MAX_OUT_HEIGHT) : CH'(r_src_h);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign ignore = r_done || (r_src_w == '0) || (r_src_h == '0);
    assign keep   = (r_src_row == r_want_row) && (r_out_col < w_clamp)
                    && (r_src_col == r_want_col);

    assign emit_fire = (r_state == ST_EMIT) && (!r_m_vld || m_axis_tready);
    assign n_out_col = r_out_col + 1'b1;
    assign fin       = (n_out_col == w_clamp) && (r_out_row == h_clamp - 1'b1);

    assign n_src_col = {1'b0, r_src_col} + 17'd1;
    assign wrap      = n_src_col >= {1'b0, r_src_w};
    assign row_hit   = (r_src_row == r_want_row);
    assign n_out_row = r_out_row + 1'b1;

    // palette memory, one write or one read per cycle, red in the top byte
    always_ff @(posedge i_clk) begin
        if (in_fire && s_axis_tuser == CMD_LOAD) begin
            r_pal_mem[s_axis_tdata[7:0]] <= {s_axis_tdata[15:8], s_axis_tdata[23:16],
                                             s_axis_tdata[31:24]};
        end
        if (in_fire && s_axis_tuser == CMD_PIXEL) begin
            r_pal_rdata <= r_pal_mem[s_axis_tdata[39:32]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAL_DEPTH; i++) r_pal_vld[i] <= 1'b0;
            r_pal_hit <= 1'b0;
        end else if (in_fire) begin
            if (s_axis_tuser == CMD_LOAD) begin
                r_pal_vld[s_axis_tdata[7:0]] <= 1'b1;
            end else begin
                r_pal_hit <= r_pal_vld[s_axis_tdata[39:32]];
            end
        end
    end

    assign pix_rgb = r_pal_hit ? r_pal_rdata : 24'h000000;

    // distance pipe: squares registered, then sum and compare
    assign rom_rgb = TGT_PAL[r_cnt[7:0]];
    assign d_r = $signed({1'b0, pix_rgb[23:16]}) - $signed({1'b0, rom_rgb[23:16]});
    assign d_g = $signed({1'b0, pix_rgb[15:8]})  - $signed({1'b0, rom_rgb[15:8]});
    assign d_b = $signed({1'b0, pix_rgb[7:0]})   - $signed({1'b0, rom_rgb[7:0]});
    assign sq_dist = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= (r_state == ST_SEARCH) && !r_cnt[8];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_r   <= 16'(d_r * d_r);
        r_sq_g   <= 16'(d_g * d_g);
        r_sq_b   <= 16'(d_b * d_b);
        r_s1_idx <= r_cnt[7:0];
        if (r_state == ST_EVAL) begin
            r_best_dist <= DIST_INIT;
            r_best_idx  <= '0;
        end else if (r_s1_vld && sq_dist < r_best_dist) begin
            // strict compare keeps the lowest index on a tie
            r_best_dist <= sq_dist;
            r_best_idx  <= r_s1_idx;
        end
    end

    assign tile_idx = (r_best_idx >= QUIRK_MIN) ? QUIRK_IDX : r_best_idx;
    assign row7     = 7'(h_clamp - 1'b1 - r_out_row);

    // divider operand select
    always_comb begin
        div_start    = 1'b0;
        div_dividend = DW'(n_out_col) * DW'(r_src_w);
        div_divisor  = CD'(w_clamp);
        if (r_state == ST_EMIT) begin
            div_start = emit_fire && !fin && (n_out_col < w_clamp);
        end else if (r_state == ST_ADV) begin
            div_dividend = DW'(n_out_row) * DW'(r_src_h);
            div_divisor  = CD'(h_clamp);
            div_start    = wrap && row_hit && (n_out_row < h_clamp);
        end
    end

    pdq_div #(
        .DW (DW),
        .VW (CD)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && s_axis_tuser == CMD_PIXEL) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (ignore)    n_state = ST_IDLE;
                else if (keep) n_state = ST_SEARCH;
                else           n_state = ST_ADV;
            end
            ST_SEARCH: begin
                if (r_cnt == 9'd257) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    if (fin)                    n_state = ST_IDLE;
                    else if (n_out_col < w_clamp) n_state = ST_DIVC;
                    else                        n_state = ST_ADV;
                end
            end
            ST_DIVC: begin
                if (div_done) n_state = ST_ADV;
            end
            ST_ADV: begin
                if (div_start) n_state = ST_DIVR;
                else           n_state = ST_IDLE;
            end
            ST_DIVR: begin
                if (div_done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // search counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                   r_cnt <= '0;
        else if (r_state == ST_EVAL)    r_cnt <= '0;
        else if (r_state == ST_SEARCH)  r_cnt <= r_cnt + 1'b1;
    end

    // configuration and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= CFG_W'(128);
            r_src_h    <= CFG_W'(128);
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_want_col <= '0;
            r_want_row <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_done     <= 1'b0;
        end else if (i_cfg_we && (i_cfg_idx == REG_SRC_WIDTH || i_cfg_idx == REG_SRC_HEIGHT)) begin
            if (i_cfg_idx == REG_SRC_WIDTH) r_src_w <= i_cfg_data;
            else                            r_src_h <= i_cfg_data;
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_want_col <= '0;
            r_want_row <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_done     <= 1'b0;
        end else begin
            case (r_state)
                ST_EMIT: begin
                    if (emit_fire) begin
                        if (fin) r_done <= 1'b1;
                        else     r_out_col <= n_out_col;
                    end
                end
                ST_DIVC: begin
                    if (div_done) r_want_col <= div_q[CFG_W-1:0];
                end
                ST_ADV: begin
                    if (wrap) begin
                        r_src_col <= '0;
                        r_src_row <= r_src_row + 1'b1;
                        if (row_hit) begin
                            // end of a kept row: next output row
                            r_out_row  <= n_out_row;
                            r_out_col  <= '0;
                            r_want_col <= '0;
                            if (n_out_row >= h_clamp) r_done <= 1'b1;
                        end
                    end else begin
                        r_src_col <= n_src_col[CFG_W-1:0];
                    end
                end
                ST_DIVR: begin
                    if (div_done) r_want_row <= div_q[CFG_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (emit_fire) begin
            r_m_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_m_data <= {2'b00, row7, 7'(r_out_col), tile_idx};
            r_m_last <= fin;
        end
    end

    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    // checks
    property p_done_after_last;
        @(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && fin) |=> r_done;
    endproperty
    assert property (p_done_after_last) else $error("tile not closed after last pixel");

    property p_col_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_col <= w_clamp;
    endproperty
    assert property (p_col_bound) else $error("output column beyond tile width");

    property p_div_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy;
    endproperty
    assert property (p_div_idle) else $error("divider started while busy");

    property p_search_len;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH && n_state == ST_EMIT) |-> (r_cnt == 9'd257);
    endproperty
    assert property (p_search_len) else $error("search left early");

endmodule

/* design/pdq_div.sv */
// restoring divider, one quotient bit per cycle
// used by the top level for the sample position scaling; depends on no package
module pdq_div #(
    parameter int DW = 24,
    parameter int VW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VW:0]      n_trial;
    logic             n_ge;

    assign n_trial = {r_rem, r_quo[DW-1]};
    assign n_ge    = n_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? VW'(n_trial - {1'b0, r_div}) : VW'(n_trial);
            r_quo <= {r_quo[DW-2:0], n_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            assert (!(i_start && r_busy))
                else $error("divider restarted while busy");
        end
    end

endmodule

/* tb/sv/tb_palette_downscale_quantizer.sv */
// testbench for palette_downscale_quantizer: palette loads and pixel streams with random
// gaps, results predicted in the testbench and checked in order
// depends on pdq_pkg (codes, register indexes, target palette) and the block itself
`timescale 1ns / 1ps

module tb_palette_downscale_quantizer;
    import pdq_pkg::*;

    localparam int MAX_W       = 128;
    localparam int MAX_H       = 128;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic       last;
        logic [6:0] row;
        logic [6:0] col;
        logic [7:0] tile_index;
    } t_tile_px;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    palette_downscale_quantizer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // predictor state: registers, source palette and frame position
    logic [15:0] src_w, src_h;
    logic [23:0] src_pal [PAL_DEPTH];
    int unsigned col_cnt, row_cnt, dx, dy, want_col, want_row;
    bit          tile_done;

    t_tile_px    expected_px[$];
    int          errors;
    int          results_seen;
    int          kept_pixels;
    int unsigned cycles;
    int unsigned stall_left;
    bit          idle_enable;

    // nearest target colour, lowest index on a tie, top eight indexes fold to 255
    function automatic logic [7:0] nearest_color(logic [23:0] rgb);
        int best, best_d, d, dr, dg, db;
        best = 0;
        best_d = 32'h7FFFFFFF;
        for (int i = 0; i < PAL_DEPTH; i++) begin
            dr = int'(rgb[23:16]) - int'(TGT_PAL[i][23:16]);
            dg = int'(rgb[15:8]) - int'(TGT_PAL[i][15:8]);
            db = int'(rgb[7:0]) - int'(TGT_PAL[i][7:0]);
            d = dr * dr + dg * dg + db * db;
            if (d < best_d) begin
                best_d = d;
                best = i;
            end
        end
        return (best >= QUIRK_MIN) ? QUIRK_IDX : 8'(best);
    endfunction

    function automatic void restart_position();
        col_cnt = 0; row_cnt = 0; dx = 0; dy = 0;
        want_col = 0; want_row = 0; tile_done = 0;
    endfunction

    // advance the downscaler by one request and queue any kept pixel
    function automatic void predict_request(logic cmd, logic [39:0] data);
        int unsigned w, h;
        t_tile_px px;
        bit fin;
        if (cmd == CMD_LOAD) begin
            src_pal[data[7:0]] = {data[15:8], data[23:16], data[31:24]};
            return;
        end
        if (tile_done || src_w == 0 || src_h == 0) return;
        w = (src_w > MAX_W) ? MAX_W : src_w;
        h = (src_h > MAX_H) ? MAX_H : src_h;
        if (row_cnt == want_row && dx < w && col_cnt == want_col) begin
            px.tile_index = nearest_color(src_pal[data[39:32]]);
            px.col = 7'(dx);
            px.row = 7'(h - 1 - dy);
            dx++;
            fin = (dx == w) && (dy == h - 1);
            px.last = fin;
            expected_px.push_back(px);
            kept_pixels++;
            if (dx < w) want_col = (dx * src_w) / w;
            if (fin) begin
                tile_done = 1;
                return;
            end
        end
        col_cnt++;
        if (col_cnt >= src_w) begin
            col_cnt = 0;
            if (row_cnt == want_row) begin
                dy++;
                dx = 0;
                want_col = 0;
                if (dy >= h) tile_done = 1;
                else want_row = (dy * src_h) / h;
            end
            row_cnt = (row_cnt + 1) & 16'hFFFF;
        end
    endfunction

    // one request on the input stream, with an optional random gap before it
    task automatic send_request(logic cmd, logic [39:0] data);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_request(cmd, data);
    endtask

    task automatic load_entry(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        send_request(CMD_LOAD, {8'($urandom), b, g, r, idx});
    endtask

    task automatic send_pixel(logic [7:0] value);
        send_request(CMD_PIXEL, {value, 32'($urandom)});
    endtask

    // wait until every kept pixel has come out, then let the search drain
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_SRC_WIDTH) src_w = value;
        else src_h = value;
        restart_position();
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        write_reg(REG_SRC_WIDTH, 16'(w));
        write_reg(REG_SRC_HEIGHT, 16'(h));
    endtask

    // palette extremes and ties
    task automatic test_directed();
        set_size(2, 2);
        load_entry(8'd0, 8'd255, 8'd255, 8'd255);
        load_entry(8'd255, 8'd0, 8'd0, 8'd0);
        load_entry(8'd1, 8'd10, 8'd10, 8'd10);
        load_entry(8'd2, 8'd170, 8'd85, 8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_pixel(8'd2);
        send_pixel(8'd0);    // after the tile is done: ignored
        send_pixel(8'd7);    // never loaded entry, but ignored too: the tile is done
        set_size(1, 1);
        send_pixel(8'd2);
        set_size(0, 3);      // empty tile
        send_pixel(8'd0);
        send_pixel(8'd1);
        set_size(3, 1);
        send_pixel(8'd0);
        send_pixel(8'd1);
        send_pixel(8'd2);
    endtask

    // a frame of random pixels, cut at limit pixels, with a sprinkling of palette loads
    task automatic run_frame(int unsigned w, int unsigned h, int unsigned limit);
        int unsigned n;
        set_size(w, h);
        n = w * h;
        if (n > limit) n = limit;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                load_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
            send_pixel(8'($urandom_range(0, 31)) |
                       ($urandom_range(0, 7) == 0 ? 8'($urandom) : 8'd0));
        end
    endtask

    task automatic test_palette_fill();
        for (int i = 0; i < 32; i++) begin
            load_entry(8'(i), 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_random_frames();
        run_frame(5, 4, 1000);
        run_frame(3, 7, 1000);
        run_frame(13, 2, 1000);
        run_frame(1, 9, 1000);
        run_frame(6, 6, 1000);
        run_frame(200, 2, 300);        // width above the clamp, partial frame
        run_frame(2, 300, 300);        // height above the clamp, partial frame
        run_frame(65535, 1, 150);      // widest source, only column zero kept early
        run_frame(1, 65535, 60);       // tallest source
        test_palette_fill();
        run_frame(129, 1, 200);
    endtask

    // last part runs without any gaps on either side
    task automatic test_full_rate();
        idle_enable = 0;
        run_frame(4, 5, 1000);
        run_frame(7, 3, 1000);
    endtask

    // result checker against the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_tile_px got, exp_px;
            got = {m_axis_tlast, m_axis_tdata[21:0]};
            results_seen++;
            if (expected_px.size() == 0) begin
                $display("%0t: unexpected result expected none got %h", $realtime, got);
                errors++;
            end else begin
                exp_px = expected_px.pop_front();
                if (got.tile_index !== exp_px.tile_index || got.col !== exp_px.col ||
                    got.row !== exp_px.row || got.last !== exp_px.last) begin
                    $display("%0t: mismatch expected idx=%0d col=%0d row=%0d last=%0d",
                             $realtime, exp_px.tile_index, exp_px.col, exp_px.row,
                             exp_px.last);
                    $display("%0t:          got idx=%0d col=%0d row=%0d last=%0d",
                             $realtime, got.tile_index, got.col, got.row, got.last);
                    errors++;
                end
            end
        end
    end

    // random output stall bursts, none in the last part
    always @(posedge i_clk) begin
        if (!idle_enable) begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        errors = 0;
        results_seen = 0;
        kept_pixels = 0;
        cycles = 0;
        stall_left = 0;
        idle_enable = 1;
        src_w = 16'd128;
        src_h = 16'd128;
        for (int i = 0; i < PAL_DEPTH; i++) src_pal[i] = '0;
        restart_position();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_frames();
        test_full_rate();
        wait_drained();
        $display("covered palette loads, clamped and unclamped sizes, empty and finished tiles");
        $display("%0d kept pixels predicted, %0d results checked", kept_pixels, results_seen);
        if (errors == 0 && expected_px.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
design/pdq_pkg.sv
design/pdq_div.sv
design/palette_downscale_quantizer.sv
tb/sv/tb_palette_downscale_quantizer.sv
